// ===== sv/pbm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pbm_pkg
// shared widths, constants and controller/datapath interface types
// ----------------------------------------------------------------------------
package pbm_pkg;

    localparam int N_W       = 10;
    localparam int VAL_W     = 30;
    localparam int N_MAX     = 1023;
    localparam int ROW_DEPTH = 512;
    localparam int ROW_AW    = $clog2(ROW_DEPTH);

    localparam logic [VAL_W-1:0] MOD_RESET = VAL_W'(1000000007);

    // one-hot commands from the controller
    typedef struct packed {
        logic load;
        logic clear;
        logic pre1;
        logic pre2;
        logic step;
        logic fetch;
        logic capture;
        logic capture_zero;
    } pbm_cmd_t;

    typedef struct packed {
        logic trivial;
        logic k_zero;
        logic clr_last;
        logic step_last;
        logic rows_last;
    } pbm_status_t;

endpackage : pbm_pkg
`default_nettype wire

// ===== sv/pbm_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pbm_ctrl
// sequencer: query check, row clear, per-row preload and update, final fetch
// ----------------------------------------------------------------------------
module pbm_ctrl
    import pbm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  pbm_status_t      status,
    output pbm_cmd_t         cmd,
    output logic             busy
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;
    localparam logic [2:0] ST_CLEAR = 3'd2;
    localparam logic [2:0] ST_PRE1  = 3'd3;
    localparam logic [2:0] ST_PRE2  = 3'd4;
    localparam logic [2:0] ST_STEP  = 3'd5;
    localparam logic [2:0] ST_FETCH = 3'd6;
    localparam logic [2:0] ST_LATCH = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (status.trivial)
                begin
                    cmd.capture_zero = 1'b1;
                    state_next       = ST_IDLE;
                end
                else
                begin
                    state_next = ST_CLEAR;
                end
            end
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (status.clr_last)
                begin
                    state_next = status.k_zero ? ST_FETCH : ST_PRE1;
                end
            end
            ST_PRE1:
            begin
                cmd.pre1   = 1'b1;
                state_next = ST_PRE2;
            end
            ST_PRE2:
            begin
                cmd.pre2   = 1'b1;
                state_next = ST_STEP;
            end
            ST_STEP:
            begin
                cmd.step = 1'b1;
                if (status.step_last)
                begin
                    state_next = status.rows_last ? ST_FETCH : ST_PRE1;
                end
            end
            ST_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = ST_LATCH;
            end
            ST_LATCH:
            begin
                cmd.capture = 1'b1;
                state_next  = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule : pbm_ctrl
`default_nettype wire

// ===== sv/pbm_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pbm_datapath
// row store, row/column counters, modular adder and result register
// ----------------------------------------------------------------------------
module pbm_datapath
    import pbm_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  pbm_cmd_t              cmd,
    output pbm_status_t           status,
    input  wire logic [N_W-1:0]   total_n,
    input  wire logic [N_W-1:0]   chosen_k,
    input  wire logic             cfg_valid,
    input  wire logic [VAL_W-1:0] cfg_data,
    output logic                  done,
    output logic [VAL_W-1:0]      coefficient
);

    logic [VAL_W-1:0]  row_mem [ROW_DEPTH];

    logic [VAL_W-1:0]  modulus_reg;
    logic [N_W-1:0]    n_reg;
    logic [ROW_AW-1:0] k_reg;
    logic              trivial_reg;
    logic [N_W-1:0]    row_reg;
    logic [ROW_AW-1:0] j_reg;
    logic [VAL_W-1:0]  upper_reg;
    logic [VAL_W-1:0]  rd_data_reg;
    logic              done_reg;
    logic [VAL_W-1:0]  coefficient_reg;

    logic [N_W-1:0]    n_minus_k;
    logic [N_W-1:0]    k_red;
    logic [ROW_AW-1:0] top;
    logic [ROW_AW-1:0] rd_addr;
    logic              wr_en;
    logic [VAL_W-1:0]  wr_data;
    logic [VAL_W:0]    sum;
    logic [VAL_W:0]    sum_sub;
    logic [VAL_W-1:0]  sum_mod;

    assign n_minus_k = total_n - chosen_k;
    assign k_red     = (n_minus_k < chosen_k) ? n_minus_k : chosen_k;

    // entries above the current row are still zero, so the row index caps top
    assign top = (row_reg < {1'b0, k_reg}) ? row_reg[ROW_AW-1:0] : k_reg;

    assign sum     = {1'b0, upper_reg} + {1'b0, rd_data_reg};
    assign sum_sub = sum - {1'b0, modulus_reg};
    assign sum_mod = (sum >= {1'b0, modulus_reg}) ? sum_sub[VAL_W-1:0] : sum[VAL_W-1:0];

    always_comb
    begin
        rd_addr = k_reg;
        if (cmd.pre1)
        begin
            rd_addr = top;
        end
        else if (cmd.pre2)
        begin
            rd_addr = j_reg - ROW_AW'(1);
        end
        else if (cmd.step)
        begin
            // operand for the next column down; wraps harmlessly at column one
            rd_addr = j_reg - ROW_AW'(2);
        end
    end

    assign wr_en   = cmd.clear || cmd.step;
    assign wr_data = cmd.step ? sum_mod
                   : ((j_reg == '0) ? VAL_W'(1) : '0);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            row_mem[j_reg] <= wr_data;
        end
        rd_data_reg <= row_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= MOD_RESET;
            done_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                modulus_reg <= cfg_data;
            end
            done_reg <= cmd.capture || cmd.capture_zero;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            n_reg       <= total_n;
            k_reg       <= k_red[ROW_AW-1:0];
            trivial_reg <= (chosen_k > total_n) || (modulus_reg < VAL_W'(2))
                        || (int'(total_n) > N_MAX) || (int'(k_red) >= ROW_DEPTH);
            row_reg     <= N_W'(1);
            j_reg       <= '0;
        end
        if (cmd.clear)
        begin
            j_reg <= j_reg + ROW_AW'(1);
        end
        if (cmd.pre1)
        begin
            j_reg <= top;
        end
        if (cmd.pre2)
        begin
            upper_reg <= rd_data_reg;
        end
        if (cmd.step)
        begin
            upper_reg <= rd_data_reg;
            j_reg     <= j_reg - ROW_AW'(1);
            if (j_reg == ROW_AW'(1))
            begin
                row_reg <= row_reg + N_W'(1);
            end
        end
        if (cmd.capture)
        begin
            coefficient_reg <= rd_data_reg;
        end
        if (cmd.capture_zero)
        begin
            coefficient_reg <= '0;
        end
    end

    assign status.trivial   = trivial_reg;
    assign status.k_zero    = (k_reg == '0);
    assign status.clr_last  = (j_reg == k_reg);
    assign status.step_last = (j_reg == ROW_AW'(1));
    assign status.rows_last = (row_reg == n_reg);

    assign done        = done_reg;
    assign coefficient = coefficient_reg;

endmodule : pbm_datapath
`default_nettype wire

// ===== sv/pascal_row_binomial_mod.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pascal_row_binomial_mod
// C(n,k) modulo a programmable modulus over a single Pascal row store
// ----------------------------------------------------------------------------
// A query is taken when start is high and busy is low; the result shows on
// coefficient for one cycle with done, and the receiver cannot stall it.
// With k' = min(k, n-k), a query loads its operands, checks them, clears
// entries 0..k' of the row store, then for each row r=1..n preloads and
// updates entries min(r,k') down to 1, and at last fetches entry k'; the
// row updates drop out when k' is zero. k > n or a modulus below two gives
// zero with no row work. The row memory has one write and one read port and
// does one read-modify-write of an entry per cycle plus a preload per row,
// and the clear of entries 0..k' opens every non-trivial query. The user must
// write the modulus register through cfg_valid/cfg_ready only while the block
// is idle (not enforced by the block); it is applied to the next query.
// ----------------------------------------------------------------------------
module pascal_row_binomial_mod
    import pbm_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire logic [N_W-1:0]   total_n,
    input  wire logic [N_W-1:0]   chosen_k,
    output logic                  done,
    output logic [VAL_W-1:0]      coefficient,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [VAL_W-1:0] cfg_data
);

    pbm_cmd_t    cmd;
    pbm_status_t status;

    assign cfg_ready = 1'b1;

    pbm_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    pbm_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .total_n     (total_n),
        .chosen_k    (chosen_k),
        .cfg_valid   (cfg_valid),
        .cfg_data    (cfg_data),
        .done        (done),
        .coefficient (coefficient)
    );

    // a result is only given once the sequencer is back in idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // an accepted item always starts a sequence
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("accepted item did not start");

    // at most one command per cycle
    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cmd))
        else $error("overlapping datapath commands");

    // last column of the last row leads to the final fetch
    a_last_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step && status.step_last && status.rows_last) |=> cmd.fetch)
        else $error("final row did not lead to fetch");

endmodule : pascal_row_binomial_mod
`default_nettype wire

// ===== verif/pascal_row_binomial_mod_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pascal_row_binomial_mod_test
// self-checking bench for the Pascal-row binomial coefficient block
// ----------------------------------------------------------------------------
// Queries (n, k) go in through start/busy with random gaps. Each query is
// predicted by running the same Pascal-row recurrence at the block's widths
// under the modulus last written. Every done strobe is checked against the
// oldest prediction. The bench covers trivial rows, field extremes, modulus
// extremes and one query at the deepest row, then runs random query mixes
// under several moduli. Most queries are kept small, because the row work of
// a query grows with n and k.
// ----------------------------------------------------------------------------
module pascal_row_binomial_mod_test;
    import pbm_pkg::*;

    typedef struct {
        logic [N_W-1:0]   n;
        logic [N_W-1:0]   k;
        logic [VAL_W-1:0] coeff;
    } query_t;

    localparam logic [VAL_W-1:0] MOD_MAX = {VAL_W{1'b1}};

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             start = 1'b0;
    logic [N_W-1:0]   total_n = '0;
    logic [N_W-1:0]   chosen_k = '0;
    logic             cfg_valid = 1'b0;
    logic [VAL_W-1:0] cfg_data = '0;
    logic             busy;
    logic             done;
    logic [VAL_W-1:0] coefficient;
    logic             cfg_ready;

    logic [VAL_W-1:0] modulus_now = MOD_RESET;
    query_t           pending_coeff[$];
    int               errors = 0;
    int               steady_left = 0;

    pascal_row_binomial_mod u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .total_n     (total_n),
        .chosen_k    (chosen_k),
        .done        (done),
        .coefficient (coefficient),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    always #5 clk = ~clk;

    // C(n,k) mod m over one Pascal row, conditional subtract per addition
    function automatic logic [VAL_W-1:0] binom_mod(input logic [N_W-1:0] n,
                                                   input logic [N_W-1:0] k,
                                                   input logic [VAL_W-1:0] m);
        logic [VAL_W-1:0] row_vals[ROW_DEPTH];
        logic [VAL_W:0]   acc;
        int               kk;
        int               top;
        int               r;
        int               j;
        if (k > n)
            return '0;
        kk = (n - k < k) ? int'(n - k) : int'(k);
        if (m < 2)
            return '0;
        if (kk >= ROW_DEPTH)
            return '0;
        for (j = 0; j <= kk; j++)
            row_vals[j] = '0;
        row_vals[0] = VAL_W'(1);
        for (r = 1; r <= int'(n); r++)
        begin
            top = (r < kk) ? r : kk;
            for (j = top; j > 0; j--)
            begin
                acc = {1'b0, row_vals[j]} + {1'b0, row_vals[j-1]};
                if (acc >= {1'b0, m})
                    acc = acc - {1'b0, m};
                row_vals[j] = acc[VAL_W-1:0];
            end
        end
        return row_vals[kk];
    endfunction

    // random gap before an item, with runs of back-to-back items
    function automatic int next_gap();
        if (steady_left > 0)
        begin
            steady_left--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0)
            steady_left = $urandom_range(4, 12);
        return $urandom_range(0, 6);
    endfunction

    task automatic send_query(input int n, input int k);
        query_t q;
        int     gap;
        gap = next_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start    <= 1'b1;
        total_n  <= N_W'(n);
        chosen_k <= N_W'(k);
        @(posedge clk);
        while (busy)
            @(posedge clk);
        q.n     = N_W'(n);
        q.k     = N_W'(k);
        q.coeff = binom_mod(q.n, q.k, modulus_now);
        pending_coeff.push_back(q);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending_coeff.size() != 0);
    endtask

    // only written with the block idle
    task automatic set_modulus(input logic [VAL_W-1:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        modulus_now = value;
        cfg_valid <= 1'b0;
    endtask

    task automatic test_trivial_rows();
        set_modulus(MOD_RESET);
        send_query(0, 0);
        send_query(1, 0);
        send_query(1, 1);
        send_query(5, 0);
        send_query(5, 5);
        // k above n
        send_query(0, 1);
        send_query(0, 1023);
        send_query(1022, 1023);
        send_query(3, 7);
        send_query(10, 3);
        send_query(20, 10);
    endtask

    task automatic test_field_extremes();
        send_query(1023, 0);
        send_query(1023, 1023);
        send_query(1023, 1022);
        send_query(1023, 1);
    endtask

    task automatic test_modulus_extremes();
        set_modulus(VAL_W'(2));
        send_query(10, 5);
        send_query(7, 3);
        set_modulus(MOD_MAX);
        send_query(62, 31);
        send_query(100, 50);
        // modulus below two gives zero everywhere
        set_modulus(VAL_W'(1));
        send_query(4, 2);
        send_query(0, 0);
        set_modulus('0);
        send_query(4, 2);
        send_query(3, 5);
        set_modulus(VAL_W'(13));
        send_query(30, 12);
    endtask

    // deepest row entry the store allows
    task automatic test_deep_row();
        set_modulus(MOD_RESET);
        send_query(1023, 511);
    endtask

    task automatic test_random_queries(input logic [VAL_W-1:0] m, input int count);
        int pick;
        int n;
        int k;
        int kr;
        set_modulus(m);
        repeat (count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                n = $urandom_range(0, 48);
                k = $urandom_range(0, n);
            end
            else if (pick < 85)
            begin
                // wide n, reduced k kept short
                n  = $urandom_range(0, 1023);
                kr = $urandom_range(0, (n < 6) ? n : 6);
                k  = $urandom_range(0, 1) ? kr : n - kr;
            end
            else
            begin
                n = $urandom_range(0, 1022);
                k = $urandom_range(n + 1, 1023);
            end
            send_query(n, k);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_coeff.size() == 0)
            begin
                $display("%0t unexpected result: expected none, actual %0d",
                         $time, coefficient);
                errors++;
            end
            else
            begin
                if (coefficient !== pending_coeff[0].coeff)
                begin
                    $display("%0t C(%0d,%0d): expected %0d, actual %0d", $time,
                             pending_coeff[0].n, pending_coeff[0].k,
                             pending_coeff[0].coeff, coefficient);
                    errors++;
                end
                void'(pending_coeff.pop_front());
            end
        end
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_trivial_rows();
        test_field_extremes();
        test_modulus_extremes();
        test_deep_row();
        test_random_queries(VAL_W'($urandom_range(2, 1073741823)), 20);
        test_random_queries(VAL_W'($urandom_range(2, 64)), 20);
        test_random_queries(MOD_RESET, 20);
        test_random_queries(MOD_MAX, 20);
        wait_drained();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #100_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
